// ===== rtl/clf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clf_pkg: shared types and constants of the channel linear fade unit
// Word layouts, configuration register indexes and fixed field widths.
// ----------------------------------------------------------------------------
package clf_pkg;

    localparam int unsigned TIME_W     = 32;
    localparam int unsigned SIZE_W     = 17;
    localparam int unsigned IDX_W      = 16;
    localparam int unsigned VAL_W      = 8;
    localparam int unsigned FADE_DUR_W = 16;
    localparam int unsigned DUR_W      = 32;
    localparam int unsigned QUOT_W     = 8;
    localparam int unsigned QBIT_W     = 3;
    localparam int unsigned REM_W      = DUR_W + QUOT_W;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    // frame sizes above this are clamped
    localparam int unsigned MAX_CHANNELS = 65536;
    localparam int unsigned FULL_LEVEL   = 255;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FADE_DURATION = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_DELAY    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REST_OF_STEP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_LENGTH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_DOWN     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_START_CHANNEL = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd6;

    typedef struct packed {
        logic [TIME_W-1:0] time_ms;
        logic              output_frame;
        logic [SIZE_W-1:0] frame_size;
        logic [IDX_W-1:0]  channel_index;
        logic [VAL_W-1:0]  channel_value;
    } t_in_word;

    typedef struct packed {
        logic [VAL_W-1:0] value_out;
        logic             was_faded;
    } t_out_word;

    typedef struct packed {
        logic [FADE_DUR_W-1:0] fade_duration_ms;
        logic [TIME_W-1:0]     fade_delay_ms;
        logic                  use_rest_of_step;
        logic [TIME_W-1:0]     step_length_ms;
        logic                  fade_down;
        logic [SIZE_W-1:0]     start_channel;
        logic [SIZE_W-1:0]     channel_count;
    } t_cfg;

    // word handed along the divider cells
    typedef struct packed {
        logic              ok;
        logic [REM_W-1:0]  rem;
        logic [DUR_W-1:0]  dur;
        logic [QUOT_W-1:0] quot;
        logic [VAL_W-1:0]  value;
    } t_cell_word;

endpackage

// ===== rtl/clf_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clf_decode: window and channel range check, dividend setup
// Two register stages: subtractions first, then the parallel compares.
// ----------------------------------------------------------------------------
module clf_decode (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  clf_pkg::t_in_word  i_word,
    input  clf_pkg::t_cfg      i_cfg,
    output logic               o_valid,
    output clf_pkg::t_cell_word o_word
);

    typedef struct packed {
        logic                         live;
        logic [clf_pkg::DUR_W-1:0]    dur;
        logic [clf_pkg::TIME_W-1:0]   elapsed;
        logic [clf_pkg::SIZE_W-1:0]   size_c;
        logic [clf_pkg::SIZE_W-1:0]   sc;
        logic [clf_pkg::SIZE_W-1:0]   first;
        logic [clf_pkg::SIZE_W:0]     cc_end;
        logic                         cc_all;
        logic [clf_pkg::IDX_W-1:0]    idx;
        logic [clf_pkg::VAL_W-1:0]    value;
    } t_front;

    logic                       r_valid_a;
    t_front                     r_front;
    t_front                     n_front;
    logic                       r_valid_b;
    clf_pkg::t_cell_word        r_word;
    clf_pkg::t_cell_word        n_word;

    logic [clf_pkg::TIME_W:0]   dur_diff;
    logic [clf_pkg::TIME_W:0]   el_diff;
    logic                       disabled;

    // stage A
    always_comb begin
        dur_diff = {1'b0, i_cfg.step_length_ms} - {1'b0, i_cfg.fade_delay_ms};
        el_diff  = {1'b0, i_word.time_ms} - {1'b0, i_cfg.fade_delay_ms};
        disabled = (i_cfg.fade_duration_ms == '0) ||
                   (i_cfg.use_rest_of_step &&
                    (dur_diff[clf_pkg::TIME_W] || dur_diff[clf_pkg::TIME_W-1:0] == '0));

        n_front.live    = i_word.output_frame && !disabled && !el_diff[clf_pkg::TIME_W];
        n_front.dur     = i_cfg.use_rest_of_step ? dur_diff[clf_pkg::TIME_W-1:0]
                        : {{(clf_pkg::DUR_W-clf_pkg::FADE_DUR_W){1'b0}},
                           i_cfg.fade_duration_ms};
        n_front.elapsed = el_diff[clf_pkg::TIME_W-1:0];
        n_front.size_c  = (i_word.frame_size > clf_pkg::SIZE_W'(clf_pkg::MAX_CHANNELS))
                        ? clf_pkg::SIZE_W'(clf_pkg::MAX_CHANNELS) : i_word.frame_size;
        // start channel zero acts as one
        n_front.sc      = (i_cfg.start_channel == '0) ? clf_pkg::SIZE_W'(1)
                        : i_cfg.start_channel;
        n_front.first   = n_front.sc - clf_pkg::SIZE_W'(1);
        n_front.cc_end  = {1'b0, n_front.first} + {1'b0, i_cfg.channel_count};
        n_front.cc_all  = (i_cfg.channel_count == '0);
        n_front.idx     = i_word.channel_index;
        n_front.value   = i_word.channel_value;
    end

    // stage B: live, in window, index in [first, size), below first + nonzero count
    always_comb begin
        n_word.ok    = r_front.live &&
                       (r_front.elapsed <= r_front.dur) &&
                       (r_front.sc <= r_front.size_c) &&
                       ({1'b0, r_front.idx} >= r_front.first) &&
                       ({1'b0, r_front.idx} < r_front.size_c) &&
                       (r_front.cc_all || ({2'b00, r_front.idx} < r_front.cc_end));
        // elapsed * 255
        n_word.rem   = {r_front.elapsed, {clf_pkg::QUOT_W{1'b0}}}
                     - {{clf_pkg::QUOT_W{1'b0}}, r_front.elapsed};
        n_word.dur   = r_front.dur;
        n_word.quot  = '0;
        n_word.value = r_front.value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
            r_valid_b <= 1'b0;
        end else begin
            r_valid_a <= i_valid;
            r_valid_b <= r_valid_a;
        end
    end

    always_ff @(posedge i_clk) begin
        r_front <= n_front;
        r_word  <= n_word;
    end

    assign o_valid = r_valid_b;
    assign o_word  = r_word;

endmodule

// ===== rtl/clf_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clf_cell: one restoring division step
// Resolves quotient bit BIT by compare and subtract of the shifted divisor.
// ----------------------------------------------------------------------------
module clf_cell #(
    parameter logic [clf_pkg::QBIT_W-1:0] BIT = '0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  clf_pkg::t_cell_word i_word,
    output logic                o_valid,
    output clf_pkg::t_cell_word o_word
);

    logic                         r_valid;
    clf_pkg::t_cell_word          r_word;
    clf_pkg::t_cell_word          n_word;
    logic [clf_pkg::REM_W-1:0]    cand;

    always_comb begin
        cand   = {{(clf_pkg::REM_W-clf_pkg::DUR_W){1'b0}}, i_word.dur} << BIT;
        n_word = i_word;
        if (i_word.rem >= cand) begin
            n_word.rem       = i_word.rem - cand;
            n_word.quot[BIT] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

// ===== rtl/clf_scale.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clf_scale: apply the fade level to the channel byte
// Optional inversion, 8x8 multiply, exact divide by 255, output register.
// ----------------------------------------------------------------------------
module clf_scale (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  clf_pkg::t_cell_word i_word,
    input  logic                i_fade_down,
    output logic                o_strobe,
    output clf_pkg::t_out_word  o_word
);

    logic                           r_strobe;
    clf_pkg::t_out_word             r_word;
    clf_pkg::t_out_word             n_word;
    logic [clf_pkg::QUOT_W-1:0]     level;
    logic [2*clf_pkg::VAL_W-1:0]    prod;
    logic [2*clf_pkg::VAL_W:0]      sum;

    // x / 255 == (x + 1 + (x >> 8)) >> 8 for every x up to 255 * 255
    always_comb begin
        level = i_fade_down ? clf_pkg::QUOT_W'(clf_pkg::FULL_LEVEL) - i_word.quot
              : i_word.quot;
        prod  = i_word.value * level;
        sum   = {1'b0, prod} + (2*clf_pkg::VAL_W+1)'(1)
              + {1'b0, {clf_pkg::VAL_W{1'b0}}, prod[2*clf_pkg::VAL_W-1:clf_pkg::VAL_W]};
        n_word.value_out = i_word.ok ? sum[2*clf_pkg::VAL_W-1:clf_pkg::VAL_W]
                         : i_word.value;
        n_word.was_faded = i_word.ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_strobe = r_strobe;
    assign o_word   = r_word;

endmodule

// ===== rtl/channel_linear_fade_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// channel_linear_fade_unit: linear fade of lighting channel bytes
// Scales each channel word by a time-driven fade level, channel range aware.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive i_in_word and raise start for one cycle per word.
//   busy is always low, so a word is taken every cycle, back to back.
//   Output channel: o_strobe is high for exactly one cycle with o_out_word;
//   the receiver has no way to stall, so it must take the word right then.
//   A word's result is registered through two decode stages, eight divider
//   cells and one scale stage before it reaches the outputs. Throughput:
//   one word per cycle, set by the cell chain, which moves every word one
//   cell on each clock.
//   Config port: i_cfg_we with i_cfg_idx / i_cfg_data writes one register;
//   indexes past the last register are ignored. Write only while no word
//   is in flight.
//   Reset (synchronous, i_rst_n low) empties the pipe, drops any word in
//   flight, and loads the register defaults: 50 ms duration, no delay,
//   fade out, start channel 1, all channels.
// ----------------------------------------------------------------------------
module channel_linear_fade_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  clf_pkg::t_in_word                   i_in_word,
    input  logic                                i_cfg_we,
    input  logic [clf_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [clf_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output logic                                o_strobe,
    output clf_pkg::t_out_word                  o_out_word
);

    // configuration registers
    clf_pkg::t_cfg r_cfg;

    // cell chain: index 0 is the decode output, QUOT_W is the last cell
    logic                v_chain [clf_pkg::QUOT_W+1];
    clf_pkg::t_cell_word w_chain [clf_pkg::QUOT_W+1];

    logic accept;

    // never stalls: a word can enter every cycle
    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fade_duration_ms <= clf_pkg::FADE_DUR_W'(50);
            r_cfg.fade_delay_ms    <= '0;
            r_cfg.use_rest_of_step <= 1'b0;
            r_cfg.step_length_ms   <= '0;
            r_cfg.fade_down        <= 1'b1;
            r_cfg.start_channel    <= clf_pkg::SIZE_W'(1);
            r_cfg.channel_count    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                clf_pkg::REG_FADE_DURATION: begin
                    r_cfg.fade_duration_ms <= i_cfg_data[clf_pkg::FADE_DUR_W-1:0];
                end
                clf_pkg::REG_FADE_DELAY: begin
                    r_cfg.fade_delay_ms <= i_cfg_data[clf_pkg::TIME_W-1:0];
                end
                clf_pkg::REG_REST_OF_STEP: begin
                    r_cfg.use_rest_of_step <= i_cfg_data[0];
                end
                clf_pkg::REG_STEP_LENGTH: begin
                    r_cfg.step_length_ms <= i_cfg_data[clf_pkg::TIME_W-1:0];
                end
                clf_pkg::REG_FADE_DOWN: begin
                    r_cfg.fade_down <= i_cfg_data[0];
                end
                clf_pkg::REG_START_CHANNEL: begin
                    r_cfg.start_channel <= i_cfg_data[clf_pkg::SIZE_W-1:0];
                end
                clf_pkg::REG_CHANNEL_COUNT: begin
                    r_cfg.channel_count <= i_cfg_data[clf_pkg::SIZE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // pass/fade decision and dividend elapsed*255
    clf_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_word  (i_in_word),
        .i_cfg   (r_cfg),
        .o_valid (v_chain[0]),
        .o_word  (w_chain[0])
    );

    // level = elapsed*255 / dur, one quotient bit per cell, MSB first.
    // The window check keeps elapsed <= dur, so eight bits cover the level.
    for (genvar g = 0; g < clf_pkg::QUOT_W; g++) begin : g_cell
        clf_cell #(
            .BIT (clf_pkg::QBIT_W'(clf_pkg::QUOT_W - 1 - g))
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (v_chain[g]),
            .i_word  (w_chain[g]),
            .o_valid (v_chain[g+1]),
            .o_word  (w_chain[g+1])
        );
    end

    // the user must keep config stable while words are in flight (not enforced here); fade_down is read live
    clf_scale u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (v_chain[clf_pkg::QUOT_W]),
        .i_word      (w_chain[clf_pkg::QUOT_W]),
        .i_fade_down (r_cfg.fade_down),
        .o_strobe    (o_strobe),
        .o_word      (o_out_word)
    );

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for channel_linear_fade_unit
// Walks a short directed list of register writes and channel words, then
// random frames under random fade settings, with and without sender gaps;
// results are checked in order against typed-in values or a fade predictor.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int PIPE_LATENCY      = 11;
    localparam int RESET_CYCLES      = 9;
    localparam int SEGMENTS          = 12;
    localparam int WORDS_PER_SEGMENT = 96;
    localparam int MAX_REPORTS       = 10;
    // index past the last register; writes to it must be ignored
    localparam logic [clf_pkg::CFG_IDX_W-1:0] REG_NONE = 3'd7;

    typedef enum bit {ROW_WRITE, ROW_WORD} t_row_kind;

    typedef struct {
        t_row_kind                      kind;
        logic [clf_pkg::CFG_IDX_W-1:0]  reg_idx;
        logic [clf_pkg::CFG_DATA_W-1:0] reg_data;
        clf_pkg::t_in_word              word;
        bit                             typed;
        clf_pkg::t_out_word             want;
    } t_fade_row;

    logic                           i_clk      = 1'b0;
    logic                           i_rst_n    = 1'b0;
    logic                           start      = 1'b0;
    logic                           busy;
    clf_pkg::t_in_word              i_in_word  = '0;
    logic                           i_cfg_we   = 1'b0;
    logic [clf_pkg::CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [clf_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                           o_strobe;
    clf_pkg::t_out_word             o_out_word;

    // travel alongside the word: typed-in expectation for directed rows
    bit                             word_typed = 1'b0;
    clf_pkg::t_out_word             word_want  = '0;

    clf_pkg::t_cfg                  fade_cfg;     // mirror of the register file
    clf_pkg::t_out_word             due_words[$]; // expected results, oldest first
    int                             fail_count = 0;
    int                             idle_pct   = 0;

    channel_linear_fade_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_in_word  (i_in_word),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_strobe   (o_strobe),
        .o_out_word (o_out_word)
    );

    always #5 i_clk = ~i_clk;

    initial begin : watchdog
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Expected output word for one channel word under setting c.
    function automatic clf_pkg::t_out_word faded_word_of(input clf_pkg::t_cfg c,
                                                         input clf_pkg::t_in_word w);
        clf_pkg::t_out_word r;
        longint unsigned    now, delay, size, span, first, reach, level;
        r.value_out = w.channel_value;
        r.was_faded = 1'b0;
        size = w.frame_size;
        if (size > clf_pkg::MAX_CHANNELS) size = clf_pkg::MAX_CHANNELS;
        if (c.fade_duration_ms == '0) return r;
        delay = c.fade_delay_ms;
        if (c.use_rest_of_step) begin
            if (c.step_length_ms <= c.fade_delay_ms) return r;
            span = longint'(c.step_length_ms) - delay;
        end else begin
            span = c.fade_duration_ms;
        end
        if (!w.output_frame) return r;
        now = w.time_ms;
        // window bound is taken without 32-bit wrap
        if (now < delay || now > delay + span) return r;
        first = (c.start_channel == '0) ? 1 : c.start_channel;
        if (first > size) return r;
        reach = size - first + 1;
        if (c.channel_count != '0 && c.channel_count < reach) reach = c.channel_count;
        if (w.channel_index < first - 1 || w.channel_index >= first - 1 + reach) return r;
        level = (now - delay) * clf_pkg::FULL_LEVEL / span;
        if (level > clf_pkg::FULL_LEVEL) level = clf_pkg::FULL_LEVEL;
        if (c.fade_down) level = clf_pkg::FULL_LEVEL - level;
        r.value_out = clf_pkg::VAL_W'(w.channel_value * level / clf_pkg::FULL_LEVEL);
        r.was_faded = 1'b1;
        return r;
    endfunction

    function automatic t_fade_row reg_row(input logic [clf_pkg::CFG_IDX_W-1:0] idx,
                                          input logic [clf_pkg::CFG_DATA_W-1:0] data);
        t_fade_row r;
        r = '{kind: ROW_WRITE, reg_idx: idx, reg_data: data, word: '0, typed: 1'b0,
              want: '0};
        return r;
    endfunction

    function automatic t_fade_row word_row(input logic [clf_pkg::TIME_W-1:0] t,
                                           input logic of,
                                           input logic [clf_pkg::SIZE_W-1:0] sz,
                                           input logic [clf_pkg::IDX_W-1:0] ci,
                                           input logic [clf_pkg::VAL_W-1:0] v);
        t_fade_row r;
        r = '{kind: ROW_WORD, reg_idx: '0, reg_data: '0, word: '0, typed: 1'b0,
              want: '0};
        r.word.time_ms       = t;
        r.word.output_frame  = of;
        r.word.frame_size    = sz;
        r.word.channel_index = ci;
        r.word.channel_value = v;
        return r;
    endfunction

    function automatic t_fade_row known_row(input logic [clf_pkg::TIME_W-1:0] t,
                                            input logic of,
                                            input logic [clf_pkg::SIZE_W-1:0] sz,
                                            input logic [clf_pkg::IDX_W-1:0] ci,
                                            input logic [clf_pkg::VAL_W-1:0] v,
                                            input logic [clf_pkg::VAL_W-1:0] ov,
                                            input logic f);
        t_fade_row r;
        r = word_row(t, of, sz, ci, v);
        r.typed          = 1'b1;
        r.want.value_out = ov;
        r.want.was_faded = f;
        return r;
    endfunction

    task automatic note_failure(input string what);
        fail_count++;
        if (fail_count <= MAX_REPORTS) $display("%s", what);
    endtask

    // One register write; the mirror follows at the edge that takes it.
    task automatic cfg_write(input logic [clf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [clf_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            clf_pkg::REG_FADE_DURATION:
                fade_cfg.fade_duration_ms = data[clf_pkg::FADE_DUR_W-1:0];
            clf_pkg::REG_FADE_DELAY:    fade_cfg.fade_delay_ms    = data;
            clf_pkg::REG_REST_OF_STEP:  fade_cfg.use_rest_of_step = data[0];
            clf_pkg::REG_STEP_LENGTH:   fade_cfg.step_length_ms   = data;
            clf_pkg::REG_FADE_DOWN:     fade_cfg.fade_down        = data[0];
            clf_pkg::REG_START_CHANNEL:
                fade_cfg.start_channel = data[clf_pkg::SIZE_W-1:0];
            clf_pkg::REG_CHANNEL_COUNT:
                fade_cfg.channel_count = data[clf_pkg::SIZE_W-1:0];
            default: ;
        endcase
    endtask

    // Random gap, then hold the word until the handshake takes it.
    task automatic put_word(input clf_pkg::t_in_word w, input bit typed,
                            input clf_pkg::t_out_word want);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < idle_pct) gap++;
        i_cfg_we <= 1'b0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start      <= 1'b1;
        i_in_word  <= w;
        word_typed <= typed;
        word_want  <= want;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    // Sender holds off until every word in flight has come back.
    task automatic drain();
        start    <= 1'b0;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        while (due_words.size() != 0) @(posedge i_clk);
    endtask

    // Pop before push: a result never belongs to the word taken at the same edge.
    always @(posedge i_clk) begin : check_words
        clf_pkg::t_out_word want;
        if (i_rst_n) begin
            if (o_strobe !== 1'b0) begin
                if (due_words.size() == 0) begin
                    note_failure($sformatf("result word at %0t with nothing expected",
                                           $realtime));
                end else begin
                    want = due_words.pop_front();
                    if (o_out_word.value_out !== want.value_out ||
                        o_out_word.was_faded !== want.was_faded)
                        note_failure($sformatf(
                        "mismatch at %0t: expected value %0d faded %0b, got value %0d faded %0b",
                            $realtime, want.value_out, want.was_faded,
                            o_out_word.value_out, o_out_word.was_faded));
                end
            end
            if (start && busy === 1'b0)
                due_words.push_back(word_typed ? word_want
                                               : faded_word_of(fade_cfg, i_in_word));
        end
    end

    initial begin : stimulus
        t_fade_row                      plan[$];
        clf_pkg::t_in_word              w;
        clf_pkg::t_out_word             none;
        logic [clf_pkg::CFG_DATA_W-1:0] v_dur, v_delay, v_step, v_start, v_count;
        longint unsigned                span;
        int                             frame_left;
        logic [clf_pkg::SIZE_W-1:0]     fsize;
        logic [clf_pkg::IDX_W-1:0]      pos;
        logic [clf_pkg::TIME_W-1:0]     ftime;
        logic                           fout;

        none = '0;
        fade_cfg.fade_duration_ms = 16'd50;
        fade_cfg.fade_delay_ms    = '0;
        fade_cfg.use_rest_of_step = 1'b0;
        fade_cfg.step_length_ms   = '0;
        fade_cfg.fade_down        = 1'b1;
        fade_cfg.start_channel    = 17'd1;
        fade_cfg.channel_count    = '0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset setting: 50 ms fade out, all channels
        plan.push_back(known_row(32'd0, 1'b1, 17'd512, 16'd0, 8'hFF, 8'hFF, 1'b1));
        plan.push_back(known_row(32'd50, 1'b1, 17'd512, 16'd0, 8'hFF, 8'h00, 1'b1));
        plan.push_back(known_row(32'd51, 1'b1, 17'd512, 16'd0, 8'hA5, 8'hA5, 1'b0));
        plan.push_back(known_row(32'd25, 1'b0, 17'd512, 16'd0, 8'hA5, 8'hA5, 1'b0));
        plan.push_back(word_row(32'd25, 1'b1, 17'd512, 16'd7, 8'd200));
        plan.push_back(known_row(32'd10, 1'b1, 17'd512, 16'd512, 8'd77, 8'd77, 1'b0));
        plan.push_back(known_row(32'd10, 1'b1, 17'd0, 16'd0, 8'd33, 8'd33, 1'b0));
        // oversized frame clamps, last channel still inside
        plan.push_back(known_row(32'd0, 1'b1, 17'h1FFFF, 16'hFFFF, 8'h5A, 8'h5A, 1'b1));
        plan.push_back(known_row(32'hFFFF_FFFF, 1'b1, 17'd512, 16'd0, 8'h11, 8'h11, 1'b0));
        plan.push_back(known_row(32'd10, 1'b1, 17'd512, 16'd0, 8'h00, 8'h00, 1'b1));
        plan.push_back(reg_row(REG_NONE, 32'hFFFF_FFFF));
        plan.push_back(known_row(32'd50, 1'b1, 17'd512, 16'd0, 8'hFF, 8'h00, 1'b1));
        // fade up
        plan.push_back(reg_row(clf_pkg::REG_FADE_DOWN, 32'd0));
        plan.push_back(known_row(32'd0, 1'b1, 17'd512, 16'd0, 8'hFF, 8'h00, 1'b1));
        plan.push_back(known_row(32'd50, 1'b1, 17'd512, 16'd0, 8'hC3, 8'hC3, 1'b1));
        // zero duration disables
        plan.push_back(reg_row(clf_pkg::REG_FADE_DURATION, 32'd0));
        plan.push_back(known_row(32'd0, 1'b1, 17'd512, 16'd0, 8'h42, 8'h42, 1'b0));
        // longest fade, delayed, start channel zero acts as one, three channels
        plan.push_back(reg_row(clf_pkg::REG_FADE_DURATION, 32'h0000_FFFF));
        plan.push_back(reg_row(clf_pkg::REG_FADE_DELAY, 32'd1000));
        plan.push_back(reg_row(clf_pkg::REG_START_CHANNEL, 32'd0));
        plan.push_back(reg_row(clf_pkg::REG_CHANNEL_COUNT, 32'd3));
        plan.push_back(known_row(32'd999, 1'b1, 17'd8, 16'd0, 8'd99, 8'd99, 1'b0));
        plan.push_back(known_row(32'd1000, 1'b1, 17'd8, 16'd2, 8'hFF, 8'h00, 1'b1));
        plan.push_back(known_row(32'd66535, 1'b1, 17'd8, 16'd3, 8'h10, 8'h10, 1'b0));
        plan.push_back(word_row(32'd40000, 1'b1, 17'd8, 16'd1, 8'hEE));
        // rest of step with step equal to delay: nothing to fade over
        plan.push_back(reg_row(clf_pkg::REG_REST_OF_STEP, 32'd1));
        plan.push_back(reg_row(clf_pkg::REG_STEP_LENGTH, 32'd1000));
        plan.push_back(known_row(32'd1000, 1'b1, 17'd8, 16'd0, 8'h7E, 8'h7E, 1'b0));
        // top of the time range, 15 ms window, last possible start channel
        plan.push_back(reg_row(clf_pkg::REG_FADE_DELAY, 32'hFFFF_FFF0));
        plan.push_back(reg_row(clf_pkg::REG_STEP_LENGTH, 32'hFFFF_FFFF));
        plan.push_back(reg_row(clf_pkg::REG_START_CHANNEL, 32'h0001_0000));
        plan.push_back(reg_row(clf_pkg::REG_CHANNEL_COUNT, 32'd0));
        plan.push_back(known_row(32'hFFFF_FFFF, 1'b1, 17'h10000, 16'hFFFF, 8'h81, 8'h81,
                                 1'b1));
        plan.push_back(known_row(32'hFFFF_FFF0, 1'b1, 17'hFFFF, 16'hFFFF, 8'h18, 8'h18,
                                 1'b0));
        plan.push_back(reg_row(clf_pkg::REG_START_CHANNEL, 32'hFFFF_FFFF));
        plan.push_back(reg_row(clf_pkg::REG_CHANNEL_COUNT, 32'hFFFF_FFFF));
        plan.push_back(known_row(32'hFFFF_FFF8, 1'b1, 17'h1FFFF, 16'hFFFF, 8'h3C, 8'h3C,
                                 1'b0));
        plan.push_back(reg_row(clf_pkg::REG_START_CHANNEL, 32'd5));
        plan.push_back(reg_row(clf_pkg::REG_CHANNEL_COUNT, 32'd2));
        plan.push_back(reg_row(clf_pkg::REG_FADE_DOWN, 32'd1));
        plan.push_back(word_row(32'hFFFF_FFF7, 1'b1, 17'd10, 16'd5, 8'hD2));

        idle_pct = 37;
        foreach (plan[k]) begin
            if (plan[k].kind == ROW_WRITE) begin
                drain();
                cfg_write(plan[k].reg_idx, plan[k].reg_data);
            end else begin
                put_word(plan[k].word, plan[k].typed, plan[k].want);
            end
        end

        // random settings, each followed by a run of frames
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            idle_pct = (seg < 4) ? 37 : (seg < 8) ? 79 : 0;
            drain();

            case ($urandom_range(0, 7))
                0:       v_dur = 0;
                1:       v_dur = 32'h0000_FFFF;
                default: v_dur = $urandom_range(1, 3000);
            endcase
            // bits above the register
            v_dur[31:clf_pkg::FADE_DUR_W] = (32 - clf_pkg::FADE_DUR_W)'($urandom);
            case ($urandom_range(0, 7))
                0:       v_delay = 0;
                1:       v_delay = 32'hFFFF_FFFF - $urandom_range(0, 70000);
                default: v_delay = $urandom_range(0, 5000);
            endcase
            case ($urandom_range(0, 3))
                0:       v_step = v_delay - $urandom_range(0, 10);
                1:       v_step = $urandom;
                default: v_step = v_delay + $urandom_range(1, 3000);
            endcase
            v_start = $urandom;
            case ($urandom_range(0, 7))
                0:       v_start[clf_pkg::SIZE_W-1:0] = '0;
                1:       v_start[clf_pkg::SIZE_W-1:0] = clf_pkg::SIZE_W'($urandom);
                default: v_start[clf_pkg::SIZE_W-1:0] =
                             clf_pkg::SIZE_W'($urandom_range(1, 16));
            endcase
            v_count = $urandom;
            case ($urandom_range(0, 7))
                0, 1:    v_count[clf_pkg::SIZE_W-1:0] = '0;
                2:       v_count[clf_pkg::SIZE_W-1:0] = clf_pkg::SIZE_W'($urandom);
                default: v_count[clf_pkg::SIZE_W-1:0] =
                             clf_pkg::SIZE_W'($urandom_range(1, 20));
            endcase
            cfg_write(clf_pkg::REG_FADE_DURATION, v_dur);
            cfg_write(clf_pkg::REG_FADE_DELAY, v_delay);
            cfg_write(clf_pkg::REG_REST_OF_STEP, $urandom);
            cfg_write(clf_pkg::REG_STEP_LENGTH, v_step);
            cfg_write(clf_pkg::REG_FADE_DOWN, $urandom);
            cfg_write(clf_pkg::REG_START_CHANNEL, v_start);
            cfg_write(clf_pkg::REG_CHANNEL_COUNT, v_count);

            frame_left = 0;
            for (int k = 0; k < WORDS_PER_SEGMENT; k++) begin
                if (frame_left == 0) begin
                    // new frame: one time stamp, channels in order
                    if ($urandom_range(0, 15) == 0) fsize = clf_pkg::SIZE_W'($urandom);
                    else fsize = clf_pkg::SIZE_W'($urandom_range(1, 24));
                    if (fsize > 24) begin
                        frame_left = $urandom_range(4, 24);
                        pos = clf_pkg::IDX_W'(fade_cfg.start_channel -
                                              $urandom_range(1, 4));
                    end else begin
                        frame_left = int'(fsize);
                        pos = '0;
                    end
                    if (fade_cfg.use_rest_of_step &&
                        fade_cfg.step_length_ms > fade_cfg.fade_delay_ms)
                        span = fade_cfg.step_length_ms - fade_cfg.fade_delay_ms;
                    else if (fade_cfg.fade_duration_ms != '0)
                        span = fade_cfg.fade_duration_ms;
                    else
                        span = 100;
                    span = span + span / 8 + 2;
                    if (span > 32'hFFFF_FFFF) span = 32'hFFFF_FFFF;
                    case ($urandom_range(0, 7))
                        0:       ftime = fade_cfg.fade_delay_ms - $urandom_range(1, 3);
                        1:       ftime = $urandom;
                        default: ftime = fade_cfg.fade_delay_ms +
                                         $urandom_range(0, clf_pkg::TIME_W'(span));
                    endcase
                    fout = ($urandom_range(0, 9) != 0);
                end
                if ($urandom_range(0, 9) == 0) begin
                    // stray word outside any frame
                    w.time_ms       = $urandom;
                    w.output_frame  = 1'($urandom);
                    w.frame_size    = clf_pkg::SIZE_W'($urandom);
                    w.channel_index = clf_pkg::IDX_W'($urandom);
                    w.channel_value = clf_pkg::VAL_W'($urandom);
                end else begin
                    w.time_ms       = ftime;
                    w.output_frame  = fout;
                    w.frame_size    = fsize;
                    w.channel_index = pos;
                    w.channel_value = clf_pkg::VAL_W'($urandom);
                    pos++;
                    frame_left--;
                end
                put_word(w, 1'b0, none);
            end
        end

        drain();
        repeat (PIPE_LATENCY + 4) @(posedge i_clk);
        if (due_words.size() != 0)
            note_failure($sformatf("%0d result words never arrived", due_words.size()));
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== channel_linear_fade_unit.f =====
rtl/clf_pkg.sv
rtl/clf_decode.sv
rtl/clf_cell.sv
rtl/clf_scale.sv
rtl/channel_linear_fade_unit.sv
dv/tb_top.sv
